### hw/rtl/shabs_pkg.sv
package shabs_pkg;

    localparam int DigestWords = 8;
    localparam int StateWords = 8;
    localparam int WindowWords = 16;

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;
    localparam logic [5:0] BlockLast = 6'd63;
    localparam logic [5:0] RoundLast = 6'd63;
    localparam logic [63:0] BlockBits = 64'd512;
    localparam logic [2:0] WordLast = 3'(DigestWords - 1);

    localparam logic [31:0] InitHash [StateWords] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } shabs_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } shabs_result_t;

    typedef struct packed {
        logic       shift_en;
        logic [7:0] shift_byte;
        logic       round_start;
        logic       round_en;
        logic [5:0] rnd;
        logic       hash_add;
        logic       hash_init;
        logic [2:0] rd_idx;
    } shabs_ctrl_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } shabs_state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### hw/rtl/shabs_sched.sv
module shabs_sched
    import shabs_pkg::*;
(
    input  logic        clk,
    input  shabs_ctrl_t ctrl,
    output logic [31:0] w_t
);

    // word 0 is the oldest: w[t] during the rounds, the first byte while absorbing
    logic [0:WindowWords-1][31:0] win_reg;
    logic [0:WindowWords-1][31:0] win_next;
    logic [32*WindowWords-1:0]    flat;
    logic [31:0]                  s0;
    logic [31:0]                  s1;
    logic [31:0]                  w_new;

    assign flat = win_reg;
    assign w_t  = win_reg[0];

    always_comb
    begin
        s0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
    end

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.shift_en)
        begin
            win_next = {flat[32*WindowWords-9:0], ctrl.shift_byte};
        end
        else if (ctrl.round_en)
        begin
            win_next = {flat[32*WindowWords-33:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

### hw/rtl/shabs_round.sv
module shabs_round
    import shabs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  shabs_ctrl_t ctrl,
    input  logic [31:0] w_t,
    output logic [31:0] rd_word
);

    logic [31:0] hash_reg [StateWords];
    logic [31:0] v_reg [StateWords];
    logic [31:0] v_next [StateWords];
    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    assign rd_word = hash_reg[ctrl.rd_idx];

    always_comb
    begin
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + big1 + ch + RoundK[ctrl.rnd] + w_t;
        t2   = big0 + maj;
        v_next = v_reg;
        if (ctrl.round_start)
        begin
            v_next = hash_reg;
        end
        else if (ctrl.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= InitHash;
        end
        else if (ctrl.hash_init)
        begin
            hash_reg <= InitHash;
        end
        else if (ctrl.hash_add)
        begin
            for (int i = 0; i < StateWords; i++)
            begin
                hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
        end
    end

endmodule

### hw/rtl/sha256_byte_stream_hasher.sv
// sha-256 over a byte stream
// item channel (item_valid, item_stall, item): action 0 absorbs item.data_byte,
// action 1 pads the message and starts the digest readout
// result channel (result_valid, result_stall, result): after a finish, eight
// transfers carry hash words 0..7, last_word set on the eighth
// an absorb transfer shifts one byte into the window; the byte that fills a
// 64-byte block starts the 64 rounds and the hash update on one shared round unit
// a finish inserts padding one byte per cycle (64 - pending bytes, or 128 -
// pending when 56 or more are pending), pausing for the rounds and hash update
// of each padded block, then loads one digest word per cycle, unless the result
// stalls, into the output register; item_stall is high from the cycle after any
// of this work starts until its hash update, or after a finish until the last
// digest word is loaded; the hash then returns to its initial value
// a stalled result holds its word and pauses the readout
// reset loads the initial hash and clears the byte and bit counts
module sha256_byte_stream_hasher
    import shabs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  shabs_item_t   item,
    output logic          result_valid,
    input  logic          result_stall,
    output shabs_result_t result
);

    shabs_state_t  state_reg;
    shabs_state_t  state_next;
    logic [5:0]    fill_reg;
    logic [5:0]    fill_next;
    logic [63:0]   bitcnt_reg;
    logic [63:0]   bitcnt_next;
    logic [63:0]   total_reg;
    logic [63:0]   total_next;
    logic [5:0]    rnd_reg;
    logic [5:0]    rnd_next;
    logic [2:0]    idx_reg;
    logic [2:0]    idx_next;
    logic          finish_reg;
    logic          finish_next;
    logic          first_reg;
    logic          first_next;
    logic          lenok_reg;
    logic          lenok_next;
    logic          final_reg;
    logic          final_next;
    logic          lenok_blk;
    logic          load_out;
    logic          valid_reg;
    shabs_result_t result_reg;
    shabs_ctrl_t   ctrl;
    logic [31:0]   w_t;
    logic [31:0]   rd_word;

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result       = result_reg;
    assign load_out     = (state_reg == ST_OUT) && (!valid_reg || !result_stall);

    shabs_sched u_sched (
        .clk  (clk),
        .ctrl (ctrl),
        .w_t  (w_t)
    );

    shabs_round u_round (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .w_t     (w_t),
        .rd_word (rd_word)
    );

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bitcnt_next = bitcnt_reg;
        total_next  = total_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        finish_next = finish_reg;
        first_next  = first_reg;
        lenok_next  = lenok_reg;
        final_next  = final_reg;
        lenok_blk   = lenok_reg;
        ctrl        = '0;
        ctrl.rnd    = rnd_reg;
        ctrl.rd_idx = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!item.action)
                    begin
                        ctrl.shift_en   = 1'b1;
                        ctrl.shift_byte = item.data_byte;
                        fill_next       = fill_reg + 6'd1;
                        if (fill_reg == BlockLast)
                        begin
                            bitcnt_next      = bitcnt_reg + BlockBits;
                            ctrl.round_start = 1'b1;
                            rnd_next         = '0;
                            state_next       = ST_ROUND;
                        end
                    end
                    else
                    begin
                        total_next  = bitcnt_reg + {55'd0, fill_reg, 3'd0};
                        finish_next = 1'b1;
                        first_next  = 1'b1;
                        lenok_next  = 1'b0;
                        final_next  = 1'b0;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                ctrl.shift_en = 1'b1;
                if (first_reg)
                begin
                    ctrl.shift_byte = PadByte;
                    first_next      = 1'b0;
                    // the length fits in this block only if the pad byte lands early enough
                    lenok_blk       = (fill_reg < LenStart);
                    lenok_next      = lenok_blk;
                end
                else if (lenok_reg && (fill_reg >= LenStart))
                begin
                    ctrl.shift_byte = total_reg[63:56];
                    total_next      = {total_reg[55:0], 8'h00};
                end
                else
                begin
                    ctrl.shift_byte = 8'h00;
                end
                fill_next = fill_reg + 6'd1;
                if (fill_reg == BlockLast)
                begin
                    ctrl.round_start = 1'b1;
                    rnd_next         = '0;
                    state_next       = ST_ROUND;
                    if (lenok_blk)
                    begin
                        final_next = 1'b1;
                    end
                    else
                    begin
                        lenok_next = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                ctrl.round_en = 1'b1;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == RoundLast)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                ctrl.hash_add = 1'b1;
                if (!finish_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (final_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == WordLast)
                    begin
                        ctrl.hash_init = 1'b1;
                        bitcnt_next    = '0;
                        fill_next      = '0;
                        finish_next    = 1'b0;
                        final_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            bitcnt_reg <= '0;
            rnd_reg    <= '0;
            idx_reg    <= '0;
            finish_reg <= 1'b0;
            first_reg  <= 1'b0;
            lenok_reg  <= 1'b0;
            final_reg  <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bitcnt_reg <= bitcnt_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            finish_reg <= finish_next;
            first_reg  <= first_next;
            lenok_reg  <= lenok_next;
            final_reg  <= final_next;
            if (load_out)
            begin
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        if (load_out)
        begin
            result_reg.digest_word <= rd_word;
            result_reg.word_index  <= idx_reg;
            result_reg.last_word   <= (idx_reg == WordLast);
        end
    end

    // the final block always ends on a block boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (fill_reg == '0))
        else $error("digest readout with bytes pending");

    // round 63 is followed by the hash update
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && (rnd_reg == RoundLast) |=> (state_reg == ST_ADD))
        else $error("compression did not end after round 63");

    // the last block of a finish must carry the length
    assert property (@(posedge clk) disable iff (!rst_n)
        final_reg |-> (lenok_reg && finish_reg))
        else $error("final block without length field");

    // digest words leave in order
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (idx_reg != '0) |-> (result_reg.word_index == idx_reg - 3'd1))
        else $error("digest word out of order");

endmodule
